// ===== rtl/core/wcc_pkg.sv =====
// Package for the word checksum block: shared constants, item type,
// CRC-32 column table and the CRC fold helper.
// No dependencies.
package wcc_pkg;

  // Default prime for the modular sum
  localparam int unsigned SUM_MODULUS_DEFAULT = 1000000007;

  // Mode register codes
  localparam logic MODE_CRC = 1'b0;
  localparam logic MODE_SUM = 1'b1;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_FOLD  = 32'h7FFF_FFFF;

  // One message word in flight
  typedef struct packed {
    logic signed [31:0] word;
    logic               last;
  } wcc_item_t;

  typedef logic [31:0] crc_cols_t [32];

  // Column i is the register after 32 shift steps starting from bit i alone.
  // Evaluated at elaboration only.
  function automatic crc_cols_t crc_cols_init();
    crc_cols_t   cols;
    logic [31:0] x;
    for (int i = 0; i < 32; i++) begin
      x = 32'h1 << i;
      for (int k = 0; k < 32; k++) begin
        x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      cols[i] = x;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols_init();

  // Four bytes through the CRC: since the word is as wide as the register,
  // the update is a fixed linear map of (crc ^ word). XOR of selected columns.
  function automatic logic [31:0] crc_word_apply(input logic [31:0] x);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ CRC_COLS[i];
      end
    end
    return r;
  endfunction

  // Reduce a 32-bit value modulo 2^31-1: add the top bit back, one subtract.
  function automatic logic [30:0] crc_fold(input logic [31:0] c);
    logic [31:0] s;
    s = {1'b0, c[30:0]} + {31'b0, c[31]};
    if (s >= CRC_FOLD) begin
      s = s - CRC_FOLD;
    end
    return s[30:0];
  endfunction

endpackage

// ===== rtl/core/wcc_reduce.sv =====
// Three-stage pipeline that reduces each signed word modulo SUM_MODULUS.
// Depends on wcc_pkg.
module wcc_reduce import wcc_pkg::*; #(
  parameter int unsigned SUM_MODULUS = SUM_MODULUS_DEFAULT,
  localparam int         SUM_W       = $clog2(SUM_MODULUS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wcc_item_t        in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output wcc_item_t        out_item,
  output logic [SUM_W-1:0] out_wmod
);

  // floor(2^32 / M) as reciprocal; offset is 2^31 mod M
  localparam logic [63:0]    RECIP64 = 64'h1_0000_0000 / 64'(SUM_MODULUS);
  localparam logic [31:0]    RECIP   = RECIP64[31:0];
  localparam logic [SUM_W:0] MOD_X   = (SUM_W+1)'(SUM_MODULUS);
  localparam logic [SUM_W:0] OFFSET  = (SUM_W+1)'(64'h8000_0000 % 64'(SUM_MODULUS));

  logic             v1, v2, v3;
  wcc_item_t        item1, item2, item3;
  logic [31:0]      quot1;
  logic [SUM_W:0]   rem2;
  logic [SUM_W-1:0] wmod3;

  logic take1, take2, take3;

  logic [31:0]    u0, u1;
  logic [63:0]    prod0;
  logic [63:0]    qm1;
  logic [63:0]    diff1;
  logic [SUM_W:0] r2;
  logic [SUM_W:0] wm2;

  // stage ready chain: a stage loads when empty or when it moves on
  assign take3    = !v3 || out_ready;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign in_ready = take1;

  // offset the signed word to unsigned: u = w + 2^31
  assign u0    = {~in_item.word[31], in_item.word[30:0]};
  assign prod0 = 64'(u0) * 64'(RECIP);

  // remainder estimate, below 2M
  assign u1    = {~item1.word[31], item1.word[30:0]};
  assign qm1   = 64'(quot1) * 64'(SUM_MODULUS);
  assign diff1 = 64'(u1) - qm1;

  // one correction, then remove the offset modulo M
  always_comb begin
    r2 = (rem2 >= MOD_X) ? (rem2 - MOD_X) : rem2;
    if (r2 >= OFFSET) begin
      wm2 = r2 - OFFSET;
    end else begin
      wm2 = r2 + MOD_X - OFFSET;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take1) v1 <= in_valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (take1) begin
      item1 <= in_item;
      quot1 <= prod0[63:32];
    end
    if (take2) begin
      item2 <= item1;
      rem2  <= diff1[SUM_W:0];
    end
    if (take3) begin
      item3 <= item2;
      wmod3 <= wm2[SUM_W-1:0];
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;
  assign out_wmod  = wmod3;

endmodule

// ===== rtl/core/wcc_accum.sv =====
// CRC and modular-sum accumulators with the result register.
// Depends on wcc_pkg.
module wcc_accum import wcc_pkg::*; #(
  parameter int unsigned SUM_MODULUS = SUM_MODULUS_DEFAULT,
  localparam int         SUM_W       = $clog2(SUM_MODULUS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  logic             item_valid,
  output logic             item_ready,
  input  wcc_item_t        item,
  input  logic [SUM_W-1:0] item_wmod,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [30:0]      res_checksum
);

  localparam logic [SUM_W:0] MOD_X = (SUM_W+1)'(SUM_MODULUS);

  logic [31:0]      crc_accum;
  logic [SUM_W-1:0] sum_accum;

  logic [31:0]      crc_next;
  logic [SUM_W:0]   sum_raw;
  logic [SUM_W-1:0] sum_next;
  logic [30:0]      result;
  logic             fire;

  // a closing word needs the result register free; others always pass
  assign item_ready = !item.last || !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  // accumulator updates
  assign crc_next = crc_word_apply(crc_accum ^ item.word);
  assign sum_raw  = {1'b0, sum_accum} + {1'b0, item_wmod};
  assign sum_next = (sum_raw >= MOD_X) ? SUM_W'(sum_raw - MOD_X) : sum_raw[SUM_W-1:0];

  // select the checksum kind
  always_comb begin
    if (mode == MODE_SUM) begin
      result = 31'(sum_next);
    end else begin
      result = crc_fold(crc_next ^ CRC_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= CRC_ONES;
      sum_accum <= '0;
    end else if (fire) begin
      if (item.last) begin
        crc_accum <= CRC_ONES;
        sum_accum <= '0;
      end else begin
        crc_accum <= crc_next;
        sum_accum <= sum_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && item.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.last) begin
      res_checksum <= result;
    end
  end

endmodule

// ===== rtl/core/word_checksum_crc32_or_modsum.sv =====
// Top level of the word checksum block: mode register, input register,
// modulo pipeline and accumulators. Depends on wcc_pkg, wcc_reduce, wcc_accum.
//
//   channel   signals                          moves
//   input     in_valid/in_ready, word, last    one message word per transaction
//   output    out_valid/out_ready, checksum    one checksum per closed message
//   config    cfg_wr_en, cfg_wr_data           mode bit, written when cfg_wr_en is high
//
// One word per cycle sustained while no closing word waits for the result register.
// A closing word passes the input register, three modulo stages (two multiplies
// and a correction), then the accumulator and result register.
// Synchronous reset clears the valids, sets both accumulators to their start values and mode to CRC.
// Stages advance independently, so bubbles fill while a checksum waits;
// a closing word holds in the last stage until the result register is free.
module word_checksum_crc32_or_modsum import wcc_pkg::*; #(
  parameter int unsigned SUM_MODULUS = SUM_MODULUS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] word,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        checksum
);

  localparam int SUM_W = $clog2(SUM_MODULUS);

  logic             mode;
  logic             v0;
  wcc_item_t        item0;
  logic             red_ready;
  logic             acc_valid;
  logic             acc_ready;
  wcc_item_t        acc_item;
  logic [SUM_W-1:0] acc_wmod;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CRC;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // input register
  assign in_ready = !v0 || red_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item0.word <= word;
      item0.last <= last;
    end
  end

  wcc_reduce #(
    .SUM_MODULUS(SUM_MODULUS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_ready (red_ready),
    .in_item  (item0),
    .out_valid(acc_valid),
    .out_ready(acc_ready),
    .out_item (acc_item),
    .out_wmod (acc_wmod)
  );

  wcc_accum #(
    .SUM_MODULUS(SUM_MODULUS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .item_valid  (acc_valid),
    .item_ready  (acc_ready),
    .item        (acc_item),
    .item_wmod   (acc_wmod),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res_checksum(checksum)
  );

endmodule

// ===== dv/wcc_checker.sv =====
// Checker for the word checksum block: watches the config, input and output
// channels, predicts each closing checksum and compares it. Depends on wcc_pkg.
module wcc_checker import wcc_pkg::*; #(
  parameter int unsigned SUM_MODULUS = SUM_MODULUS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] word,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [30:0]        checksum,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [30:0] checksum;
    int          msg_no;
  } checksum_exp_t;

  checksum_exp_t checksum_q[$];

  // Model state: both accumulators run on every word
  logic [31:0] crc_run;
  logic [29:0] sum_run;
  logic        mode_q;
  int          msg_no;

  // Reflected CRC-32, one bit at a time, low byte first
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [31:0] w);
    logic [31:0] r;
    r = c;
    for (int b = 0; b < 4; b++) begin
      r = r ^ {24'b0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
    end
    return r;
  endfunction

  // Signed word added into the running sum, kept in [0, SUM_MODULUS)
  function automatic logic [29:0] sum_feed(input logic [29:0] a, input logic signed [31:0] w);
    longint s;
    s = (longint'(a) + longint'(w)) % longint'(SUM_MODULUS);
    if (s < 0) begin
      s = s + longint'(SUM_MODULUS);
    end
    return s[29:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] checker: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    checksum_exp_t exp_item;
    longint unsigned crc_fin;
    if (rst) begin
      crc_run = CRC_ONES;
      sum_run = '0;
      mode_q  = MODE_CRC;
      msg_no  = 0;
      checksum_q.delete();
    end else begin
      // Mode register
      if (cfg_wr_en) begin
        mode_q = cfg_wr_data;
      end

      // Result transaction: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (checksum_q.size() == 0) begin
          report_mismatch($sformatf("unexpected checksum %h", checksum));
        end else begin
          exp_item = checksum_q.pop_front();
          if (checksum !== exp_item.checksum) begin
            report_mismatch($sformatf("message %0d checksum got %h expected %h",
                                      exp_item.msg_no, checksum, exp_item.checksum));
          end
        end
      end

      // Word transaction: update both accumulators, predict on the closing word
      if (in_valid && in_ready) begin
        crc_run = crc_feed(crc_run, word);
        sum_run = sum_feed(sum_run, word);
        if (last) begin
          if (mode_q == MODE_CRC) begin
            crc_fin = {32'b0, crc_run ^ CRC_ONES} % {32'b0, CRC_FOLD};
            exp_item.checksum = crc_fin[30:0];
          end else begin
            exp_item.checksum = {1'b0, sum_run};
          end
          exp_item.msg_no = msg_no;
          checksum_q.insert(checksum_q.size(), exp_item);
          msg_no++;
          crc_run = CRC_ONES;
          sum_run = '0;
        end
      end
    end
    pending <= checksum_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for word_checksum_crc32_or_modsum: clock, reset, stimulus
// and verdict. Depends on wcc_pkg, the block and wcc_checker.
module tb import wcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 80;
  localparam int PRESSURE_ITEMS = 30;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 200;
  localparam int CYCLE_LIMIT    = 300000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] word = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [30:0]        checksum;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  word_checksum_crc32_or_modsum #(
    .SUM_MODULUS(SUM_MODULUS_DEFAULT)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word       (word),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .checksum   (checksum)
  );

  wcc_checker #(
    .SUM_MODULUS(SUM_MODULUS_DEFAULT)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word       (word),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .checksum   (checksum),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Reset asserted from time zero, then released
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until the transaction completes
  task automatic send_word(input logic [31:0] w, input logic l);
    in_valid <= 1'b1;
    word     <= w;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every checksum, then let words without a result clear
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mix of full-range words, small values and values near the sign boundary
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      1:       return 32'($urandom_range(0, 255));
      2:       return -32'($urandom_range(1, 256));
      3:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      4:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  initial begin : stim
    logic mode_sel;
    while (rst) @(posedge clk);

    set_mode(MODE_CRC);

    // CRC: one-word messages at the word extremes
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    // CRC: longer message
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
    send_word(32'hFFFF_FFFB, 1'b1);

    // Message opened in CRC mode, closed in sum mode: full-message sum expected
    send_word(32'h0000_0064, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    set_mode(MODE_SUM);
    send_word(32'h0000_0007, 1'b1);

    // Sum: negative and extreme words
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    // Sum wrapping past the modulus several times
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b1);

    // Message opened in sum mode, closed in CRC mode
    send_word(32'hA5A5_5A5A, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    set_mode(MODE_CRC);
    send_word(32'h0F0F_F0F0, 1'b1);

    // Random phases, mode alternating; a phase may end inside a message
    for (int ph = 0; ph < PHASES; ph++) begin
      mode_sel = (ph % 2 == 1) ? MODE_SUM : MODE_CRC;
      set_mode(mode_sel);
      if (ph == PHASES - 1) begin
        idle_on = 1'b0;
      end
      if (ph == 2) begin
        // Long output hold-off while one-word messages keep coming
        hold_req = 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
          send_word(rand_word(), 1'b1);
        end
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        maybe_gap();
        send_word(rand_word(), $urandom_range(0, 3) == 0);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
